### rtl/mdn_pkg.sv
// ----------------------------------------------------------------------------
// mdn_pkg
// Shared types, constants and microcode table for the median-of-25 block.
// ----------------------------------------------------------------------------
package mdn_pkg;

   localparam int SAMPLE_WIDTH = 16;
   localparam int WINDOW_SIZE  = 25;
   localparam int ADDR_W       = 5;
   localparam int MID_POS      = 12;
   localparam int NET_PAIRS    = 120;
   localparam int PC_W         = 7;

   typedef logic [ADDR_W-1:0]              addr_type;
   typedef logic [PC_W-1:0]                pc_type;
   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   localparam addr_type LAST_SLOT = addr_type'(WINDOW_SIZE - 1);

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_CX,
      OP_READ_MID,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type   op;
      addr_type addr_a;
      addr_type addr_b;
   } uword_type;

   typedef enum logic [1:0] {
      PH_READ,
      PH_CMP,
      PH_SWAP
   } phase_type;

   typedef enum logic [1:0] {
      WSEL_SAMPLE,
      WSEL_RD_A,
      WSEL_RD_B
   } wsel_type;

   typedef struct packed {
      logic     we;
      addr_type waddr;
      wsel_type wsel;
      logic     rd_en;
      addr_type raddr_a;
      addr_type raddr_b;
      logic     emit;
   } dp_ctrl_type;

   typedef struct packed {
      logic swap;
      logic out_free;
   } seq_stat_type;

   // compare-exchange pairs {lo, hi} in network order
   localparam logic [2*ADDR_W-1:0] CX_PAIRS [NET_PAIRS] = '{
      {5'd1,5'd2},   {5'd3,5'd4},   {5'd5,5'd6},   {5'd7,5'd8},
      {5'd9,5'd10},  {5'd11,5'd12}, {5'd13,5'd14}, {5'd15,5'd16},
      {5'd17,5'd18}, {5'd19,5'd20}, {5'd21,5'd22}, {5'd23,5'd24},
      {5'd1,5'd3},   {5'd2,5'd4},   {5'd5,5'd7},   {5'd6,5'd8},
      {5'd9,5'd11},  {5'd10,5'd12}, {5'd13,5'd15}, {5'd14,5'd16},
      {5'd17,5'd19}, {5'd18,5'd20}, {5'd21,5'd23}, {5'd22,5'd24},
      {5'd2,5'd3},   {5'd6,5'd7},   {5'd10,5'd11}, {5'd14,5'd15},
      {5'd18,5'd19}, {5'd22,5'd23},
      {5'd1,5'd5},   {5'd2,5'd6},   {5'd3,5'd7},   {5'd4,5'd8},
      {5'd9,5'd13},  {5'd10,5'd14}, {5'd11,5'd15}, {5'd12,5'd16},
      {5'd17,5'd21}, {5'd18,5'd22}, {5'd19,5'd23}, {5'd20,5'd24},
      {5'd3,5'd5},   {5'd4,5'd6},   {5'd11,5'd13}, {5'd12,5'd14},
      {5'd19,5'd21}, {5'd20,5'd22},
      {5'd2,5'd3},   {5'd4,5'd5},   {5'd6,5'd7},   {5'd10,5'd11},
      {5'd12,5'd13}, {5'd14,5'd15}, {5'd18,5'd19}, {5'd20,5'd21},
      {5'd22,5'd23},
      {5'd0,5'd8},
      {5'd9,5'd17},  {5'd10,5'd18}, {5'd11,5'd19}, {5'd12,5'd20},
      {5'd13,5'd21}, {5'd14,5'd22}, {5'd15,5'd23}, {5'd16,5'd24},
      {5'd0,5'd4},
      {5'd13,5'd17}, {5'd14,5'd18}, {5'd15,5'd19}, {5'd16,5'd20},
      {5'd0,5'd2},   {5'd3,5'd5},   {5'd4,5'd6},
      {5'd11,5'd13}, {5'd12,5'd14}, {5'd15,5'd17}, {5'd16,5'd18},
      {5'd19,5'd21}, {5'd20,5'd22},
      {5'd0,5'd1},   {5'd2,5'd3},   {5'd4,5'd5},   {5'd6,5'd7},
      {5'd9,5'd10},  {5'd11,5'd12}, {5'd13,5'd14}, {5'd15,5'd16},
      {5'd17,5'd18}, {5'd19,5'd20}, {5'd21,5'd22},
      {5'd0,5'd16},  {5'd1,5'd17},  {5'd2,5'd18},  {5'd3,5'd19},
      {5'd4,5'd20},  {5'd5,5'd21},  {5'd6,5'd22},  {5'd7,5'd23},
      {5'd1,5'd9},   {5'd2,5'd10},  {5'd3,5'd11},  {5'd4,5'd12},
      {5'd5,5'd13},  {5'd6,5'd14},  {5'd7,5'd15},  {5'd8,5'd16},
      {5'd5,5'd9},   {5'd6,5'd10},  {5'd7,5'd11},  {5'd8,5'd12},
      {5'd13,5'd17}, {5'd14,5'd18}, {5'd15,5'd19}, {5'd16,5'd20},
      {5'd11,5'd13}, {5'd12,5'd14}, {5'd12,5'd13}, {5'd10,5'd12},
      {5'd8,5'd12}
   };

   // program: load, one step per pair, read middle entry, emit
   function automatic uword_type ucode_rom(input pc_type pc);
      uword_type w;
      pc_type    idx;
      w.op     = OP_LOAD;
      w.addr_a = '0;
      w.addr_b = '0;
      idx      = pc - pc_type'(1);
      if (pc == '0) begin
         w.op = OP_LOAD;
      end else if (pc <= pc_type'(NET_PAIRS)) begin
         w.op     = OP_CX;
         w.addr_a = CX_PAIRS[idx][2*ADDR_W-1:ADDR_W];
         w.addr_b = CX_PAIRS[idx][ADDR_W-1:0];
      end else if (pc == pc_type'(NET_PAIRS + 1)) begin
         w.op     = OP_READ_MID;
         w.addr_a = addr_type'(MID_POS);
      end else if (pc == pc_type'(NET_PAIRS + 2)) begin
         w.op = OP_EMIT;
      end
      return w;
   endfunction

endpackage

### rtl/mdn_dp.sv
// ----------------------------------------------------------------------------
// mdn_dp
// Window store with one write and two registered read ports, plus comparator.
// ----------------------------------------------------------------------------
module mdn_dp (
   input  logic                      clock,
   input  mdn_pkg::sample_type       req_sample,
   input  mdn_pkg::dp_ctrl_type      ctrl,
   output logic                      swap,
   output mdn_pkg::sample_type       rd_a
);
   import mdn_pkg::*;

   sample_type mem [WINDOW_SIZE];
   sample_type rd_a_ff;
   sample_type rd_b_ff;
   sample_type wdata;

   always_comb begin
      case (ctrl.wsel)
         WSEL_SAMPLE: wdata = req_sample;
         WSEL_RD_A:   wdata = rd_a_ff;
         WSEL_RD_B:   wdata = rd_b_ff;
         default:     wdata = req_sample;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         mem[ctrl.waddr] <= wdata;
      end
      if (ctrl.rd_en) begin
         rd_a_ff <= mem[ctrl.raddr_a];
         rd_b_ff <= mem[ctrl.raddr_b];
      end
   end

   // equal values stay put
   assign swap = (rd_a_ff > rd_b_ff);
   assign rd_a = rd_a_ff;

endmodule

### rtl/mdn_seq.sv
// ----------------------------------------------------------------------------
// mdn_seq
// Microcode sequencer: step counter, sub-step phase and load count.
// ----------------------------------------------------------------------------
module mdn_seq (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mdn_pkg::seq_stat_type     stat,
   output mdn_pkg::dp_ctrl_type      ctrl
);
   import mdn_pkg::*;

   pc_type    pc_ff, pc_in;
   phase_type phase_ff, phase_in;
   addr_type  count_ff, count_in;
   uword_type uw;

   assign uw = ucode_rom(pc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         phase_ff <= PH_READ;
         count_ff <= '0;
      end else begin
         pc_ff    <= pc_in;
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      pc_in        = pc_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      req_ready    = 1'b0;
      ctrl.we      = 1'b0;
      ctrl.waddr   = uw.addr_a;
      ctrl.wsel    = WSEL_SAMPLE;
      ctrl.rd_en   = 1'b0;
      ctrl.raddr_a = uw.addr_a;
      ctrl.raddr_b = uw.addr_b;
      ctrl.emit    = 1'b0;
      case (uw.op)
         OP_LOAD: begin
            req_ready  = 1'b1;
            ctrl.waddr = count_ff;
            if (req_valid) begin
               ctrl.we = 1'b1;
               if (count_ff == LAST_SLOT) begin
                  count_in = '0;
                  pc_in    = pc_ff + pc_type'(1);
               end else begin
                  count_in = count_ff + addr_type'(1);
               end
            end
         end
         OP_CX: begin
            case (phase_ff)
               PH_READ: begin
                  ctrl.rd_en = 1'b1;
                  phase_in   = PH_CMP;
               end
               PH_CMP: begin
                  // no swap: skip both writes
                  if (stat.swap) begin
                     ctrl.we    = 1'b1;
                     ctrl.waddr = uw.addr_a;
                     ctrl.wsel  = WSEL_RD_B;
                     phase_in   = PH_SWAP;
                  end else begin
                     phase_in = PH_READ;
                     pc_in    = pc_ff + pc_type'(1);
                  end
               end
               PH_SWAP: begin
                  ctrl.we    = 1'b1;
                  ctrl.waddr = uw.addr_b;
                  ctrl.wsel  = WSEL_RD_A;
                  phase_in   = PH_READ;
                  pc_in      = pc_ff + pc_type'(1);
               end
               default: begin
                  phase_in = PH_READ;
               end
            endcase
         end
         OP_READ_MID: begin
            ctrl.rd_en = 1'b1;
            pc_in      = pc_ff + pc_type'(1);
         end
         OP_EMIT: begin
            if (stat.out_free) begin
               ctrl.emit = 1'b1;
               pc_in     = '0;
            end
         end
         default: begin
            pc_in = '0;
         end
      endcase
   end

endmodule

### rtl/median_of_25_network.sv
// ----------------------------------------------------------------------------
// median_of_25_network
// Median of each group of 25 signed samples by a sequenced compare-exchange
// network over a small window store.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_sample  (16b signed)
//  rsp     | out       | rsp_valid / rsp_ready | rsp_median  (16b signed)
//
//  Samples are taken only while the sequencer loads. After the 25th, it runs 120
//  compare-exchange steps (read, compare, and two writes when the pair swaps),
//  then reads the middle entry and emits it; no samples are taken meanwhile.
//  The single-write window store is why a swap needs two write phases.
//  Synchronous reset clears the step counter, load count and output valid.
//  A result still waiting at the next emit step holds that step, and with it
//  the loads of the following window, until the receiver takes it.
// ----------------------------------------------------------------------------
module median_of_25_network (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [mdn_pkg::SAMPLE_WIDTH-1:0] req_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [mdn_pkg::SAMPLE_WIDTH-1:0] rsp_median
);
   import mdn_pkg::*;

   dp_ctrl_type  ctrl;
   seq_stat_type stat;
   logic         swap;
   sample_type   rd_a;
   logic         rsp_valid_ff;
   sample_type   rsp_median_ff;

   assign stat.swap     = swap;
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   mdn_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   mdn_dp u_dp (
      .clock      (clock),
      .req_sample (req_sample),
      .ctrl       (ctrl),
      .swap       (swap),
      .rd_a       (rd_a)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_median_ff <= rd_a;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule

### rtl/mdn_checker.sv
// ----------------------------------------------------------------------------
// mdn_checker
// Port-level checks for the median block, bound to the top level.
// ----------------------------------------------------------------------------
module mdn_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic signed [mdn_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [mdn_pkg::SAMPLE_WIDTH-1:0] rsp_median
);
   import mdn_pkg::*;

   sample_type sample_seen;

   assign sample_seen = req_sample;

   // stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_median))
      else $error("rsp_median changed while stalled");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // the network runs its compare-exchange steps after the last item
   a_no_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (sample_seen == req_sample) |=> !$rose(rsp_valid))
      else $error("result appeared right after an item");

   a_emit_not_loading: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result emitted while taking items");

endmodule

bind median_of_25_network mdn_checker u_mdn_checker (.*);
